[rtl/plen_pkg.sv]
`default_nettype none

package plen_pkg;

  // coordinate width used by the arithmetic (low bits of each coordinate field)
  localparam int COORD_BITS = 16;

  // widths of the stream fields
  localparam int X_W       = 16;
  localparam int Y_W       = 16;
  localparam int CHAIN_W   = 32;
  localparam int TOTAL_W   = 48;
  localparam int IN_DATA_W = ((X_W + Y_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CHAIN_W + TOTAL_W + 7) / 8) * 8;

  // effective coordinate width after masking to the field width
  localparam int CW     = (COORD_BITS < X_W) ? COORD_BITS : X_W;
  // squared distance, root and partial remainder widths
  localparam int SQ_W   = 2 * CW + 1;
  localparam int ROOT_W = CW + 1;
  localparam int VP_W   = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  localparam logic [CHAIN_W-1:0] CHAIN_MAX = {CHAIN_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

`default_nettype wire

[rtl/plen_sqdist.sv]
`default_nettype none

module plen_sqdist
  import plen_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [CW-1:0]   dx_i,
  input  wire logic [CW-1:0]   dy_i,
  output logic                 done_o,
  output logic [SQ_W-1:0]      sq_o
);

  logic            phase_q, phase_d;
  logic            done_q, done_d;
  logic [SQ_W-1:0] sq_q, sq_d;
  logic [CW-1:0]   mop;
  logic [2*CW-1:0] prod;

  // one multiplier, dx squared first and dy squared in the next cycle
  assign mop  = phase_q ? dy_i : dx_i;
  assign prod = mop * mop;

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    sq_d    = sq_q;
    if (start_i) begin
      sq_d    = {1'b0, prod};
      phase_d = 1'b1;
    end else if (phase_q) begin
      sq_d    = sq_q + {1'b0, prod};
      phase_d = 1'b0;
      done_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign done_o = done_q;
  assign sq_o   = sq_q;

endmodule

`default_nettype wire

[rtl/plen_isqrt.sv]
`default_nettype none

module plen_isqrt
  import plen_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SQ_W-1:0]   value_i,
  output logic                   done_o,
  output logic [ROOT_W-1:0]      root_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [VP_W-1:0]   val_q, val_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // one root bit per cycle: bring down two bits, try (root << 2) | 1
  assign rem_sh = {rem_q[REM_W-3:0], val_q[VP_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(ROOT_W - 1);
      val_d  = {{(VP_W-SQ_W){1'b0}}, value_i};
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      val_d  = {val_q[VP_W-3:0], 2'b00};
      rem_d  = fits ? (rem_sh - trial) : rem_sh;
      root_d = {root_q[ROOT_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[rtl/polyline_length_accumulator_top.sv]
// Polyline length accumulator.
// Input stream: one point per transaction. s_axis_tdata_i carries x (bits 15:0)
// and y (bits 31:16) in units of 0.01, s_axis_tlast_i marks the last point of a
// chain. Output stream: one transaction per finished chain, m_axis_tdata_o holds
// the chain length (bits 31:0) and the saturating total over all chains since
// reset (bits 79:32).
// The first point of a chain is only stored. Every later point is accepted,
// runs through the shared squarer (dx*dx, then + dy*dy), a load and the
// bit-serial square root (one root bit per cycle), and then its segment is
// added to the chain sum. The last point of a chain then passes through a
// state that folds the chain into the total and loads the output register.
// s_axis_tready_o is high only while no point is in work.
// The output register holds a result until the receiver takes it; a stalled
// receiver blocks the block only when a second result is ready to be loaded.
// Reset clears the previous point, the chain sum, the total and the output
// valid flag.
`default_nettype none

module polyline_length_accumulator_top
  import plen_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // x_coord, y_coord
  input  wire logic                  s_axis_tlast_i,   // last_point
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o    // chain_length, total_length
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic               have_prev_q, have_prev_d;
  logic               last_q, last_d;
  logic               start_q, start_d;
  logic [CW-1:0]      prev_x_q, prev_x_d;
  logic [CW-1:0]      prev_y_q, prev_y_d;
  logic [CW-1:0]      dx_q, dx_d;
  logic [CW-1:0]      dy_q, dy_d;
  logic [CHAIN_W-1:0] chain_q, chain_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAIN_W-1:0] out_chain_q, out_chain_d;
  logic [TOTAL_W-1:0] out_total_q, out_total_d;

  logic               in_xfer;
  logic [CW-1:0]      x_in, y_in;
  logic               sq_done;
  logic [SQ_W-1:0]    sq;
  logic               root_done;
  logic [ROOT_W-1:0]  root;
  logic [CHAIN_W:0]   chain_add;
  logic [TOTAL_W:0]   total_add;
  logic [CHAIN_W-1:0] chain_sat;
  logic [TOTAL_W-1:0] total_sat;
  logic               out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign x_in            = s_axis_tdata_i[CW-1:0];
  assign y_in            = s_axis_tdata_i[X_W +: CW];

  assign chain_add = {1'b0, chain_q} + (CHAIN_W+1)'(root);
  assign chain_sat = chain_add[CHAIN_W] ? CHAIN_MAX : chain_add[CHAIN_W-1:0];
  assign total_add = {1'b0, total_q} + (TOTAL_W+1)'(chain_q);
  assign total_sat = total_add[TOTAL_W] ? TOTAL_MAX : total_add[TOTAL_W-1:0];
  assign out_free  = !out_valid_q || m_axis_tready_i;

  plen_sqdist u_sqdist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .dx_i   (dx_q),
    .dy_i   (dy_q),
    .done_o (sq_done),
    .sq_o   (sq)
  );

  plen_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_done),
    .value_i(sq),
    .done_o (root_done),
    .root_o (root)
  );

  always_comb begin
    state_d     = state_q;
    have_prev_d = have_prev_q;
    last_d      = last_q;
    start_d     = 1'b0;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    chain_d     = chain_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_chain_d = out_chain_q;
    out_total_d = out_total_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          dx_d        = (x_in >= prev_x_q) ? (x_in - prev_x_q) : (prev_x_q - x_in);
          dy_d        = (y_in >= prev_y_q) ? (y_in - prev_y_q) : (prev_y_q - y_in);
          prev_x_d    = x_in;
          prev_y_d    = y_in;
          last_d      = s_axis_tlast_i;
          have_prev_d = 1'b1;
          if (have_prev_q) begin
            start_d = 1'b1;
            state_d = ST_SQ;
          end else if (s_axis_tlast_i) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_SQ: begin
        if (sq_done) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          chain_d = chain_sat;
          state_d = last_q ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_chain_d = chain_q;
          out_total_d = total_sat;
          total_d     = total_sat;
          chain_d     = '0;
          have_prev_d = 1'b0;
          prev_x_d    = '0;
          prev_y_d    = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      start_q     <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      chain_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      start_q     <= start_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      chain_q     <= chain_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q      <= last_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    out_chain_q <= out_chain_d;
    out_total_q <= out_total_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_total_q, out_chain_q});

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plen_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          RANDOM_POINTS = 770;

  typedef struct packed {
    logic [CHAIN_W-1:0] chain_len;
    logic [TOTAL_W-1:0] total_len;
  } chain_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // x_coord, y_coord
  logic                  s_axis_tlast = 1'b0; // last_point
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // chain_length, total_length

  polyline_length_accumulator_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // predicted state of the accumulator
  logic [63:0]   last_x;
  logic [63:0]   last_y;
  bit            chain_open;
  logic [63:0]   chain_acc;
  logic [63:0]   total_acc;

  chain_result_t pending_lengths[$];
  int            mismatch_count;
  int            points_sent;
  int            chains_seen;
  int unsigned   cycle_count;
  bit            steady_flow;
  int            hold_request;

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [32:0] r;
    logic [32:0] cand;
    logic [65:0] sq;
    r = '0;
    for (int i = 32; i >= 0; i--) begin
      cand = r | (33'd1 << i);
      sq = cand * cand;
      if (sq <= {2'b00, v}) r = cand;
    end
    return {31'd0, r};
  endfunction

  function automatic logic [63:0] segment_span(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] dx;
    logic [63:0] dy;
    logic [64:0] sq_sum;
    dx = (x >= last_x) ? x - last_x : last_x - x;
    dy = (y >= last_y) ? y - last_y : last_y - y;
    sq_sum = {1'b0, dx * dx} + {1'b0, dy * dy};
    // a square sum beyond 64 bits counts as the largest segment
    if (sq_sum[64]) return {32'd0, CHAIN_MAX};
    return floor_root(sq_sum[63:0]);
  endfunction

  // advance the predicted state by one point; returns 1 when a chain closes
  function automatic bit trace_point(input logic [X_W-1:0] xc, input logic [Y_W-1:0] yc,
                                     input bit last, output chain_result_t res);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] seg;
    mask = (COORD_BITS >= 64) ? '1 : ((64'd1 << COORD_BITS) - 64'd1);
    x = {48'd0, xc} & mask;
    y = {48'd0, yc} & mask;
    res = '0;
    if (chain_open) begin
      seg = segment_span(x, y);
      if (seg >= {32'd0, CHAIN_MAX} - chain_acc) chain_acc = {32'd0, CHAIN_MAX};
      else chain_acc = chain_acc + seg;
    end
    last_x = x;
    last_y = y;
    chain_open = 1'b1;
    if (!last) return 1'b0;
    if (chain_acc >= {16'd0, TOTAL_MAX} - total_acc) total_acc = {16'd0, TOTAL_MAX};
    else total_acc = total_acc + chain_acc;
    res.chain_len = chain_acc[CHAIN_W-1:0];
    res.total_len = total_acc[TOTAL_W-1:0];
    chain_acc = '0;
    chain_open = 1'b0;
    last_x = '0;
    last_y = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_point(input logic [X_W-1:0] x, input logic [Y_W-1:0] y, input bit last);
    int gap;
    chain_result_t res;
    gap = steady_flow ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    points_sent++;
    if (trace_point(x, y, last, res)) pending_lengths.push_back(res);
  endtask

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 18);
      if (hold_request > 0) begin
        stall = stall + hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    chain_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      chains_seen++;
      if (pending_lengths.size() == 0) begin
        report_mismatch($sformatf("result with none pending, data %h", m_axis_tdata));
      end else begin
        want = pending_lengths.pop_front();
        if (m_axis_tdata[CHAIN_W-1:0] !== want.chain_len)
          report_mismatch($sformatf("chain_length %0d, predicted %0d",
                                    m_axis_tdata[CHAIN_W-1:0], want.chain_len));
        if (m_axis_tdata[CHAIN_W+TOTAL_W-1:CHAIN_W] !== want.total_len)
          report_mismatch($sformatf("total_length %0d, predicted %0d",
                                    m_axis_tdata[CHAIN_W+TOTAL_W-1:CHAIN_W], want.total_len));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_lengths.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one-point chains give zero length
  task automatic test_single_points();
    send_point(16'h0000, 16'h0000, 1'b1);
    send_point(16'hFFFF, 16'hFFFF, 1'b1);
    send_point(16'hAAAA, 16'h5555, 1'b1);
    send_point(16'h5555, 16'hAAAA, 1'b1);
  endtask

  task automatic test_segment_shapes();
    // longest diagonal
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 1'b1);
    // horizontal, vertical, crossing diagonal
    send_point(16'hFFFF, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'h0000, 16'hFFFF, 1'b0);
    send_point(16'hFFFF, 16'h0000, 1'b1);
    // repeated point adds nothing
    send_point(16'd1234, 16'd1234, 1'b0);
    send_point(16'd1234, 16'd1234, 1'b1);
    // 3-4-5 there and back, then a step that rounds down
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd3, 16'd4, 1'b0);
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd1, 16'd1, 1'b1);
    // backwards steps
    send_point(16'd500, 16'd900, 1'b0);
    send_point(16'd100, 16'd200, 1'b1);
  endtask

  // receiver holds off while points keep coming, so the block backs up
  task automatic test_output_stall();
    steady_flow = 1'b1;
    hold_request = 400;
    for (int i = 0; i < 8; i++) begin
      send_point(16'($urandom), 16'($urandom), i[0]);
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_random_chains(input int target);
    int          n_pts;
    int          pick;
    logic [15:0] x;
    logic [15:0] y;
    while (points_sent < target) begin
      if ($urandom_range(0, 29) == 0) steady_flow = ~steady_flow;
      n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      x = 16'($urandom);
      y = 16'($urandom);
      for (int k = 0; k < n_pts; k++) begin
        if (k > 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) begin
            x = 16'($urandom);
            y = 16'($urandom);
          end else if (pick < 8) begin
            x = x + 16'($urandom_range(0, 256)) - 16'd128;
            y = y + 16'($urandom_range(0, 256)) - 16'd128;
          end else if (pick == 8) begin
            x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          end
        end
        send_point(x, y, k == n_pts - 1);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    last_x = '0;
    last_y = '0;
    chain_open = 1'b0;
    chain_acc = '0;
    total_acc = '0;
    mismatch_count = 0;
    points_sent = 0;
    chains_seen = 0;
    steady_flow = 1'b0;
    hold_request = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_points();
    test_segment_shapes();
    test_output_stall();
    test_random_chains(RANDOM_POINTS);
    s_axis_tvalid <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("sent %0d points, checked %0d chain results, final total %0d",
             points_sent, chains_seen, total_acc);
    $display("covered one-point chains, extreme segments, output back-pressure, random chains");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/plen_pkg.sv
rtl/plen_sqdist.sv
rtl/plen_isqrt.sv
rtl/polyline_length_accumulator_top.sv
tb/testbench.sv
